FILE: rtl/core/sialu_pkg.sv
// Shared types and constants for the four-operation signed ALU.
// No dependencies.
`default_nettype none
package sialu_pkg;
   localparam int WordWidth = 32;
   localparam int StageCount = 32;

   localparam logic [7:0] OP_ADD = 8'd43;
   localparam logic [7:0] OP_SUB = 8'd45;
   localparam logic [7:0] OP_MUL = 8'd42;
   localparam logic [7:0] OP_DIV = 8'd47;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_UNKNOWN  = 2'd2;

   // Data moving from one divider cell to the next
   typedef struct packed {
      logic                 valid;
      logic [WordWidth-1:0] rem;     // partial remainder
      logic [WordWidth-1:0] quo;     // quotient bits shifted in low, dividend bits out high
      logic [WordWidth-1:0] den;     // divisor magnitude
      logic                 neg;     // negate quotient at the end
      logic [WordWidth-1:0] early;   // result for non-divide ops
      logic [1:0]           status;
      logic                 is_div;
   } cell_data_type;
endpackage
`default_nettype wire

FILE: rtl/core/sialu_cell.sv
// One restoring-division cell: a single quotient bit, registered.
// Depends on sialu_pkg.
`default_nettype none
module sialu_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire sialu_pkg::cell_data_type d_in,
   output sialu_pkg::cell_data_type     d_out
);
   import sialu_pkg::*;

   cell_data_type d_ff;
   cell_data_type d_in_c;
   logic [WordWidth:0] trial;
   logic [WordWidth:0] shifted;

   // Shift in next dividend bit, trial subtract
   always_comb begin
      shifted = {d_in.rem, d_in.quo[WordWidth-1]};
      trial   = shifted - {1'b0, d_in.den};
      d_in_c  = d_in;
      if (d_in.is_div) begin
         if (!trial[WordWidth]) begin
            d_in_c.rem = trial[WordWidth-1:0];
         end else begin
            d_in_c.rem = shifted[WordWidth-1:0];
         end
         d_in_c.quo = {d_in.quo[WordWidth-2:0], ~trial[WordWidth]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (advance) begin
         d_ff <= d_in_c;
      end
   end

   assign d_out = d_ff;
endmodule
`default_nettype wire

FILE: rtl/core/signed_integer_four_op_alu.sv
// Four-operation signed 32-bit ALU: top level with front stage, cell chain, output.
// Depends on sialu_pkg and sialu_cell.
// A taken request passes the front register, the 32 cells and the output register in order.
// Throughput: one beat per cycle while the skid register is empty.
// The chain advances while the skid register is empty; a held response parks one beat there.
// Synchronous active-high reset clears all valid bits; payload is not reset.
`default_nettype none
module signed_integer_four_op_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_operation,
   input  wire logic signed [31:0] req_left_operand,
   input  wire logic signed [31:0] req_right_operand,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_value,
   output logic [1:0]              rsp_status
);
   import sialu_pkg::*;

   cell_data_type chain [StageCount+1];
   cell_data_type front_in;
   logic          advance;
   logic [31:0]   mul_prod;
   logic [31:0]   a_mag;
   logic [31:0]   b_mag;
   logic [31:0]   q_final;
   logic [31:0]   out_value_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic        skid_valid_ff;
   logic [31:0] skid_value_ff;
   logic [1:0]  skid_status_ff;

   // Stall only while a beat is parked in the skid register
   assign advance   = !skid_valid_ff;
   assign req_stall = !advance;

   // Front stage: fast ops and divider setup
   always_comb begin
      a_mag = req_left_operand[31] ? 32'(-req_left_operand) : req_left_operand;
      b_mag = req_right_operand[31] ? 32'(-req_right_operand) : req_right_operand;
      mul_prod = 32'(req_left_operand * req_right_operand);
      front_in        = '0;
      front_in.valid  = req_valid;
      front_in.quo    = a_mag;
      front_in.den    = b_mag;
      front_in.neg    = req_left_operand[31] ^ req_right_operand[31];
      front_in.status = ST_OK;
      case (req_operation)
         OP_ADD: front_in.early = 32'(req_left_operand + req_right_operand);
         OP_SUB: front_in.early = 32'(req_left_operand - req_right_operand);
         OP_MUL: front_in.early = mul_prod;
         OP_DIV: begin
            if (req_right_operand == 32'sd0) begin
               front_in.status = ST_DIV_ZERO;
            end else begin
               front_in.is_div = 1'b1;
            end
         end
         default: front_in.status = ST_UNKNOWN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].valid <= 1'b0;
      end else if (advance) begin
         chain[0] <= front_in;
      end
   end

   // Divider cell chain
   for (genvar i = 0; i < StageCount; i++) begin : g_cell
      sialu_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .d_in    (chain[i]),
         .d_out   (chain[i+1])
      );
   end

   // Output select and sign fix
   always_comb begin
      q_final = chain[StageCount].neg ? 32'(-chain[StageCount].quo) : chain[StageCount].quo;
      out_value_in = chain[StageCount].is_div ? q_final : chain[StageCount].early;
   end

   // Output register with one-beat skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // chain frozen; refill output from skid once the held beat is taken
         if (!rsp_stall) begin
            rsp_value_ff  <= skid_value_ff;
            rsp_status_ff <= skid_status_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_valid_ff && rsp_stall) begin
         // output held; park the arriving beat
         skid_valid_ff  <= chain[StageCount].valid;
         skid_value_ff  <= out_value_in;
         skid_status_ff <= chain[StageCount].status;
      end else begin
         rsp_valid_ff  <= chain[StageCount].valid;
         rsp_value_ff  <= out_value_in;
         rsp_status_ff <= chain[StageCount].status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // Error results carry zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == 32'd0)
      else $error("error response with nonzero value");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response changed");
endmodule
`default_nettype wire
